@@ rtl/rsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared widths and operation codes of the reference-counted slot allocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned SLOT_INDEX_W = 16;
  localparam int unsigned ALLOC_SLOT_W = 10;
  localparam int unsigned FREE_COUNT_W = 11;

  // The in-use bitmap is kept in words of this many slots.
  localparam int unsigned BMP_W = 32;
  localparam int unsigned BIT_W = 5;

  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_GET   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd3;

endpackage

@@ rtl/rsa_req_if.sv @@
// ----------------------------------------------------------------------------
// rsa_req_if
// Request channel: one operation per beat.
// ----------------------------------------------------------------------------
interface rsa_req_if;
  logic                                     valid;
  logic                                     ready;
  logic [rsa_pkg::OPCODE_W-1:0]             opcode;
  logic signed [rsa_pkg::SLOT_INDEX_W-1:0]  slot_index;

  modport source (output valid, output opcode, output slot_index, input ready);
  modport sink   (input valid, input opcode, input slot_index, output ready);
endinterface

@@ rtl/rsa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rsa_rsp_if
// Response channel: one result per beat.
// ----------------------------------------------------------------------------
interface rsa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              status;
  logic [rsa_pkg::ALLOC_SLOT_W-1:0]  alloc_slot;
  logic                              slot_valid;
  logic [rsa_pkg::FREE_COUNT_W-1:0]  free_count;

  modport source (output valid, output status, output alloc_slot, output slot_valid,
                  output free_count, input ready);
  modport sink   (input valid, input status, input alloc_slot, input slot_valid,
                  input free_count, output ready);
endinterface

@@ rtl/rsa_ram.sv @@
// ----------------------------------------------------------------------------
// rsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/refcounted_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// refcounted_slot_allocator
// Per-slot reference counts with first-fit allocation of free slots.
// ----------------------------------------------------------------------------
//  channel | dir | beat carries
//  --------+-----+-----------------------------------------------------
//  req_i   | in  | opcode, slot_index
//  rsp_o   | out | status, alloc_slot, slot_valid, free_count
//
//  Each operation is accepted in ST_IDLE, where it reads the count RAM and the
//  bitmap RAM, and is then modified and written back from ST_EXEC.
//  After reset the block sweeps both RAMs, one entry a cycle, through all
//  NUM_SLOTS count entries before it accepts its first request.
//  A result waiting in the output register does not block the next accept,
//  but the write-back of that next operation waits until the register frees.
// ----------------------------------------------------------------------------
module refcounted_slot_allocator #(
  parameter int unsigned NUM_SLOTS   = 1024,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsa_req_if.sink     req_i,
  rsa_rsp_if.source   rsp_o
);

  localparam int unsigned SW     = $clog2(NUM_SLOTS);
  localparam int unsigned FCW    = $clog2(NUM_SLOTS + 1);
  localparam int unsigned NWORDS = (NUM_SLOTS + rsa_pkg::BMP_W - 1) / rsa_pkg::BMP_W;
  localparam int unsigned WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned XW     = WW + rsa_pkg::BIT_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [SW-1:0]                 clr_q, clr_d;
  logic [FCW-1:0]                free_q, free_d;
  logic [NWORDS-1:0]             full_q, full_d;

  logic [rsa_pkg::OPCODE_W-1:0]  op_q;
  logic [SW-1:0]                 idx_q;
  logic                          ok_q;
  logic                          none_q;
  logic [WW-1:0]                 word_q;

  logic                          rsp_valid_q;
  logic                          status_q;
  logic [rsa_pkg::ALLOC_SLOT_W-1:0] alloc_slot_q;
  logic                          slot_valid_q;
  logic [rsa_pkg::FREE_COUNT_W-1:0] free_count_q;

  logic                          accept;
  logic                          commit;
  logic                          in_range;
  logic [SW-1:0]                 req_idx;
  logic [XW-1:0]                 req_idx_x;
  logic [WW-1:0]                 free_word;

  logic                          cnt_we, cnt_re;
  logic [SW-1:0]                 cnt_waddr, cnt_raddr;
  logic [COUNT_WIDTH-1:0]        cnt_wdata, cnt_rdata;

  logic                          bmp_we, bmp_re;
  logic [WW-1:0]                 bmp_waddr, bmp_raddr;
  logic [rsa_pkg::BMP_W-1:0]     bmp_wdata, bmp_rdata;
  logic [rsa_pkg::BMP_W-1:0]     pad_word;

  logic [XW-1:0]                 idx_x;
  logic [rsa_pkg::BIT_W-1:0]     free_bit;
  logic [rsa_pkg::BMP_W-1:0]     alloc_mask, put_mask;
  logic [SW-1:0]                 alloc_slot;
  logic                          cnt_nz;
  logic                          get_ok, put_ok, put_frees;
  logic                          res_status, res_valid;

  assign accept = req_i.valid && req_i.ready;
  assign commit = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = (state_q == ST_IDLE);

  assign in_range  = !req_i.slot_index[rsa_pkg::SLOT_INDEX_W-1] &&
                     (32'(req_i.slot_index[rsa_pkg::SLOT_INDEX_W-2:0]) < NUM_SLOTS);
  assign req_idx   = req_i.slot_index[SW-1:0];
  assign req_idx_x = XW'(req_idx);

  // Lowest bitmap word that still holds a free slot.
  always_comb begin
    free_word = '0;
    for (int k = NWORDS - 1; k >= 0; k--) begin
      if (!full_q[k]) begin
        free_word = WW'(k);
      end
    end
  end

  // Slots past NUM_SLOTS in the last word are marked in use so that they are never granted.
  always_comb begin
    pad_word = '0;
    for (int j = 0; j < rsa_pkg::BMP_W; j++) begin
      pad_word[j] = ((32'(clr_q) * rsa_pkg::BMP_W + j) >= NUM_SLOTS);
    end
  end

  // Lowest free slot within the word that was read.
  always_comb begin
    free_bit = '0;
    for (int j = rsa_pkg::BMP_W - 1; j >= 0; j--) begin
      if (!bmp_rdata[j]) begin
        free_bit = rsa_pkg::BIT_W'(j);
      end
    end
  end

  assign idx_x      = XW'(idx_q);
  assign alloc_mask = rsa_pkg::BMP_W'(1) << free_bit;
  assign put_mask   = rsa_pkg::BMP_W'(1) << idx_x[rsa_pkg::BIT_W-1:0];
  assign alloc_slot = SW'({word_q, free_bit});

  assign cnt_nz    = (cnt_rdata != '0);
  assign get_ok    = ok_q && cnt_nz && (cnt_rdata != '1);
  assign put_ok    = ok_q && cnt_nz;
  assign put_frees = put_ok && (cnt_rdata == COUNT_WIDTH'(1));

  always_comb begin
    res_status = 1'b1;
    res_valid  = 1'b0;
    unique case (op_q)
      rsa_pkg::OP_ALLOC: res_status = none_q;
      rsa_pkg::OP_GET:   res_status = !get_ok;
      rsa_pkg::OP_PUT:   res_status = !put_ok;
      rsa_pkg::OP_QUERY: begin
        res_status = 1'b0;
        res_valid  = ok_q && cnt_nz;
      end
      default: res_status = 1'b1;
    endcase
  end

  // RAM ports.
  always_comb begin
    cnt_re    = accept;
    cnt_raddr = req_idx;
    bmp_re    = accept;
    bmp_raddr = (req_i.opcode == rsa_pkg::OP_ALLOC) ? free_word
                                                   : req_idx_x[XW-1:rsa_pkg::BIT_W];
    cnt_we    = 1'b0;
    cnt_waddr = idx_q;
    cnt_wdata = '0;
    bmp_we    = 1'b0;
    bmp_waddr = word_q;
    bmp_wdata = bmp_rdata;
    if (state_q == ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q;
      bmp_we    = (32'(clr_q) < NWORDS);
      bmp_waddr = WW'(clr_q);
      bmp_wdata = pad_word;
    end else if (commit) begin
      unique case (op_q)
        rsa_pkg::OP_ALLOC: begin
          cnt_we    = !none_q;
          cnt_waddr = alloc_slot;
          cnt_wdata = COUNT_WIDTH'(1);
          bmp_we    = !none_q;
          bmp_wdata = bmp_rdata | alloc_mask;
        end
        rsa_pkg::OP_GET: begin
          cnt_we    = get_ok;
          cnt_wdata = cnt_rdata + COUNT_WIDTH'(1);
        end
        rsa_pkg::OP_PUT: begin
          cnt_we    = put_ok;
          cnt_wdata = cnt_rdata - COUNT_WIDTH'(1);
          bmp_we    = put_frees;
          bmp_wdata = bmp_rdata & ~put_mask;
        end
        rsa_pkg::OP_QUERY: cnt_we = 1'b0;
        default:           cnt_we = 1'b0;
      endcase
    end
  end

  // Control next state.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    free_d  = free_q;
    full_d  = full_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + SW'(1);
        if (clr_q == SW'(NUM_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_d = ST_IDLE;
          if (op_q == rsa_pkg::OP_ALLOC && !none_q) begin
            free_d         = free_q - FCW'(1);
            full_d[word_q] = &(bmp_rdata | alloc_mask);
          end else if (op_q == rsa_pkg::OP_PUT && put_frees) begin
            free_d         = free_q + FCW'(1);
            full_d[word_q] = 1'b0;
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      free_q      <= FCW'(NUM_SLOTS);
      full_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      free_q  <= free_d;
      full_q  <= full_d;
      if (commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.opcode;
      idx_q  <= req_idx;
      ok_q   <= in_range;
      none_q <= (free_q == '0);
      word_q <= (req_i.opcode == rsa_pkg::OP_ALLOC) ? free_word
                                                    : req_idx_x[XW-1:rsa_pkg::BIT_W];
    end
    if (commit) begin
      status_q     <= res_status;
      alloc_slot_q <= (op_q == rsa_pkg::OP_ALLOC && !none_q)
                      ? rsa_pkg::ALLOC_SLOT_W'(alloc_slot) : '0;
      slot_valid_q <= res_valid;
      free_count_q <= rsa_pkg::FREE_COUNT_W'(free_d);
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.alloc_slot = alloc_slot_q;
  assign rsp_o.slot_valid = slot_valid_q;
  assign rsp_o.free_count = free_count_q;

  rsa_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_SLOTS),
    .AW    (SW)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  rsa_ram #(
    .WIDTH (rsa_pkg::BMP_W),
    .DEPTH (NWORDS),
    .AW    (WW)
  ) u_bmp_ram (
    .clk_i   (clk_i),
    .we_i    (bmp_we),
    .waddr_i (bmp_waddr),
    .wdata_i (bmp_wdata),
    .re_i    (bmp_re),
    .raddr_i (bmp_raddr),
    .rdata_o (bmp_rdata)
  );

`ifndef NO_ASSERTIONS
  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FCW'(NUM_SLOTS))
    else $error("free count exceeds the number of slots");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("request accepted while another operation is in flight");

  a_alloc_takes_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && op_q == rsa_pkg::OP_ALLOC && !none_q |=> free_q == $past(free_q) - FCW'(1))
    else $error("granted alloc did not consume exactly one free slot");

  a_empty_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && free_q == '0 |-> &full_q)
    else $error("summary shows a free word while the free count is zero");
`endif

endmodule
